/* design/two_class_priority_list_top_macros.svh */
// Assertion macros used by the top level of the two-class priority list design.
`ifndef TWO_CLASS_PRIORITY_LIST_TOP_MACROS_SVH
`define TWO_CLASS_PRIORITY_LIST_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TCPL_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcpl assertion failed");
`define TCPL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcpl assertion failed");
`else
`define TCPL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TCPL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/tcpl_pkg.sv */
// Types and codes of the two-class priority list.
`timescale 1ns / 1ps
package tcpl_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_LIST   = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_DELETED  = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_ENTRY    = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] patient_id;
    logic [6:0]  age;
    logic        urgent;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_id;
    logic [6:0]  out_age;
    logic        out_urgent;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] id;
    logic [6:0]  age;
    logic        urg;
  } entry_t;

endpackage

/* design/tcpl_store.sv */
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module tcpl_store
  import tcpl_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/two_class_priority_list_top.sv */
// Top level of the two-class priority list: command sequencer and entry memory.
//
// Usage: a command (insert, delete by id, list all) is a transfer on cmd at a
// rising edge where start is high and busy is low. Results come back on result,
// each valid for exactly one cycle while result_valid is high; the receiver
// cannot stall, so every result must be taken when shown. The final result of
// a command carries last = 1.
// Urgent entries form a prefix of the list, tracked by an urgent count, so an
// insert position is known at once. Command handling, one port each way:
//   insert at the tail (normal, or urgent with no normal entries): written
//   from idle, busy stays low; insert ahead of normal entries: each is moved
//   up a slot from the tail down (S_INS), then the entry is written (S_INS_FIN);
//   delete or list: the memory is walked one entry per cycle through its
//   single read port, shifting down behind a match; full insert, empty delete,
//   empty list: answered from idle. Worst case is set by the read port.
// Reset (rst, synchronous) empties the list; stored entries are not cleared,
// only entries below the count are ever read. Kind three is ignored.
`timescale 1ns / 1ps
`include "two_class_priority_list_top_macros.svh"
module two_class_priority_list_top
  import tcpl_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic result_valid,
  output res_t result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_INS     = 5'b00010,
    S_INS_FIN = 5'b00100,
    S_DEL     = 5'b01000,
    S_LIST    = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ucount, ucount_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] ra, ra_next;
  logic [CW-1:0] rd_idx;
  logic          issuing, issuing_next;
  logic          rd_pend;
  logic          found, found_next;
  entry_t        gone, gone_next;
  cmd_t          cmd_q;
  res_t          result_next;
  logic          result_valid_next;

  // Memory port signals.
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  logic          accept;
  logic [CW-1:0] ins_pos;
  logic [CW-1:0] last_idx;
  logic [CW-1:0] rd_up, rd_down;
  logic          hit;
  logic          known_kind;
  entry_t        del_entry;

  tcpl_store #(.DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  // Urgent entries occupy the head, so an urgent insert lands right after them.
  assign ins_pos  = cmd.urgent ? ucount : count;
  assign last_idx = count - ONE;
  assign rd_up    = rd_idx + ONE;
  assign rd_down  = rd_idx - ONE;
  assign hit      = (rdata.id == cmd_q.patient_id);
  assign del_entry = found ? gone : rdata;
  // Only the three named kinds produce results; the fourth is ignored.
  assign known_kind = (cmd.kind == KIND_INSERT) || (cmd.kind == KIND_DELETE) ||
                      (cmd.kind == KIND_LIST);

  always_comb begin
    state_next        = state;
    count_next        = count;
    ucount_next       = ucount;
    pos_next          = pos;
    ra_next           = ra;
    issuing_next      = issuing;
    found_next        = found;
    gone_next         = gone;
    result_next       = '0;
    result_valid_next = 1'b0;
    we                = 1'b0;
    waddr             = '0;
    wdata             = rdata;
    re                = 1'b0;
    raddr             = ra[AW-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.kind)
            KIND_INSERT: begin
              if (count == CAP) begin
                result_valid_next  = 1'b1;
                result_next.status = ST_FULL;
                result_next.last   = 1'b1;
              end else if (ins_pos == count) begin
                // Nothing to move: write straight at the tail.
                we                 = 1'b1;
                waddr              = count[AW-1:0];
                wdata              = '{id: cmd.patient_id, age: cmd.age, urg: cmd.urgent};
                count_next         = count + ONE;
                ucount_next        = ucount + CW'(cmd.urgent);
                result_valid_next  = 1'b1;
                result_next.status = ST_INSERTED;
                result_next.last   = 1'b1;
              end else begin
                pos_next     = ins_pos;
                ra_next      = last_idx;
                issuing_next = 1'b1;
                state_next   = S_INS;
              end
            end
            KIND_DELETE, KIND_LIST: begin
              if (count == '0) begin
                result_valid_next  = 1'b1;
                result_next.status = ST_EMPTY;
                result_next.last   = 1'b1;
              end else begin
                ra_next      = '0;
                issuing_next = 1'b1;
                found_next   = 1'b0;
                state_next   = (cmd.kind == KIND_DELETE) ? S_DEL : S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_INS: begin
        // Walk down from the tail, each entry being written one slot higher from
        // its registered read data.
        if (issuing) begin
          re = 1'b1;
          if (ra == pos) begin
            issuing_next = 1'b0;
          end else begin
            ra_next = ra - ONE;
          end
        end
        if (rd_pend) begin
          we    = 1'b1;
          waddr = rd_up[AW-1:0];
          wdata = rdata;
          if (rd_idx == pos) begin
            state_next = S_INS_FIN;
          end
        end
      end

      S_INS_FIN: begin
        we                 = 1'b1;
        waddr              = pos[AW-1:0];
        wdata              = '{id: cmd_q.patient_id, age: cmd_q.age, urg: cmd_q.urgent};
        count_next         = count + ONE;
        ucount_next        = ucount + CW'(cmd_q.urgent);
        result_valid_next  = 1'b1;
        result_next.status = ST_INSERTED;
        result_next.last   = 1'b1;
        state_next         = S_IDLE;
      end

      S_DEL: begin
        // One pass: search for the first match, then every later entry is
        // written back one slot lower as it is read.
        if (issuing) begin
          re = 1'b1;
          if (ra == last_idx) begin
            issuing_next = 1'b0;
          end
          ra_next = ra + ONE;
        end
        if (rd_pend) begin
          if (!found) begin
            if (hit) begin
              found_next = 1'b1;
              gone_next  = rdata;
            end
          end else begin
            we    = 1'b1;
            waddr = rd_down[AW-1:0];
            wdata = rdata;
          end
          if (rd_idx == last_idx) begin
            state_next        = S_IDLE;
            result_valid_next = 1'b1;
            result_next.last  = 1'b1;
            if (found || hit) begin
              result_next.status     = ST_DELETED;
              result_next.out_id     = del_entry.id;
              result_next.out_age    = del_entry.age;
              result_next.out_urgent = del_entry.urg;
              count_next             = count - ONE;
              ucount_next            = ucount - CW'(del_entry.urg);
            end else begin
              result_next.status = ST_NOTFOUND;
            end
          end
        end
      end

      S_LIST: begin
        if (issuing) begin
          re = 1'b1;
          if (ra == last_idx) begin
            issuing_next = 1'b0;
          end
          ra_next = ra + ONE;
        end
        if (rd_pend) begin
          result_valid_next      = 1'b1;
          result_next.status     = ST_ENTRY;
          result_next.out_id     = rdata.id;
          result_next.out_age    = rdata.age;
          result_next.out_urgent = rdata.urg;
          result_next.last       = (rd_idx == last_idx);
          if (rd_idx == last_idx) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      ucount       <= '0;
      issuing      <= 1'b0;
      rd_pend      <= 1'b0;
      found        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      ucount       <= ucount_next;
      issuing      <= issuing_next;
      rd_pend      <= re;
      found        <= found_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    ra     <= ra_next;
    rd_idx <= ra;
    gone   <= gone_next;
    result <= result_next;
    if (accept) begin
      cmd_q <= cmd;
    end
  end

  `TCPL_ASSERT_IMPL(a_ucount_le_count, clk, rst, 1'b1, ucount <= count)
  `TCPL_ASSERT_IMPL(a_count_le_cap, clk, rst, 1'b1, count <= CAP)
  `TCPL_ASSERT_NEXT(a_cmd_answered, clk, rst, accept && known_kind, busy || result_valid)
  `TCPL_ASSERT_IMPL(a_last_ends_busy, clk, rst, result_valid, result.last != busy)

endmodule

/* test/two_class_priority_list_top_test.sv */
// Self-checking testbench for the two-class priority list top level.
`timescale 1ns / 1ps
module two_class_priority_list_top_test;
  import tcpl_pkg::*;

  // The block is built at its default size, so the list fills after 32 inserts.
  localparam int DEPTH = 32;
  // A delete or list walks the whole list, so this covers the slowest command.
  localparam int SETTLE_CYCLES = DEPTH + 8;
  // The fourth value of the kind field has no name in the package and is ignored.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic result_valid;
  res_t result;

  // The predicted list, head first. Urgent entries always form a prefix.
  entry_t roster[$];
  // Results that the predicted list says are still on their way, oldest first.
  res_t   pending_res[$];
  int     mismatches = 0;
  // Number of transfers left in the current burst of commands.
  int     burst_left;
  // When set, the sender keeps start high and never inserts gaps.
  bit     steady;

  two_class_priority_list_top #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .result_valid(result_valid),
    .result(result)
  );

  // An 8 ns clock; rising edges fall at 4 ns, 12 ns, and so on.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Prints one line per mismatch and counts it. The run goes on afterwards.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  function automatic res_t make_res(input logic [2:0] st, input entry_t e,
                                    input logic fin);
    res_t r;
    r.status     = st;
    r.out_id     = e.id;
    r.out_age    = e.age;
    r.out_urgent = e.urg;
    r.last       = fin;
    return r;
  endfunction

  // Applies one accepted command to the predicted list and queues the results
  // that it must produce.
  function automatic void predict_cmd(input cmd_t c);
    entry_t fresh;
    int pos;
    fresh.id  = c.patient_id;
    fresh.age = c.age;
    fresh.urg = c.urgent;
    case (c.kind)
      KIND_INSERT: begin
        if (roster.size() >= DEPTH) begin
          // A full list drops the entry and says so.
          pending_res.push_back(make_res(ST_FULL, '0, 1'b1));
        end else begin
          // A normal entry goes at the tail. An urgent one goes behind the last
          // urgent entry, which is the tail when every entry is urgent.
          pos = roster.size();
          if (c.urgent) begin
            pos = 0;
            while (pos < roster.size() && roster[pos].urg) pos++;
          end
          roster.insert(pos, fresh);
          pending_res.push_back(make_res(ST_INSERTED, '0, 1'b1));
        end
      end
      KIND_DELETE: begin
        if (roster.size() == 0) begin
          pending_res.push_back(make_res(ST_EMPTY, '0, 1'b1));
        end else begin
          // Only the first matching entry in list order goes away.
          pos = 0;
          while (pos < roster.size() && roster[pos].id != c.patient_id) pos++;
          if (pos >= roster.size()) begin
            pending_res.push_back(make_res(ST_NOTFOUND, '0, 1'b1));
          end else begin
            pending_res.push_back(make_res(ST_DELETED, roster[pos], 1'b1));
            roster.delete(pos);
          end
        end
      end
      KIND_LIST: begin
        if (roster.size() == 0) begin
          pending_res.push_back(make_res(ST_EMPTY, '0, 1'b1));
        end else begin
          foreach (roster[i]) begin
            pending_res.push_back(make_res(ST_ENTRY, roster[i], i == roster.size() - 1));
          end
        end
      end
      default: begin
        // The unused kind leaves the list alone and produces nothing.
      end
    endcase
  endfunction

  // Sends one command and waits for the edge where the transfer happens.
  // Outside a steady stretch, the end of a burst lowers start for a random gap.
  task automatic send_cmd(input logic [1:0] kind, input logic [31:0] id,
                          input logic [6:0] age, input logic urg);
    cmd_t c;
    c.kind       = kind;
    c.patient_id = id;
    c.age        = age;
    c.urgent     = urg;
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    predict_cmd(c);
    if (burst_left > 0) burst_left--;
    if (!steady && burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
  endtask

  // Holds the sender off until every predicted result has come back. Start is
  // lowered ahead of the wait so that it is never lowered and raised in one step.
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  // Every result strobe is matched, field by field, with the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (!rst && result_valid !== 1'b0) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected result", 64'(result), '0);
      end else begin
        want = pending_res.pop_front();
        if (result.status !== want.status)
          report_mismatch("status", 64'(result.status), 64'(want.status));
        if (result.out_id !== want.out_id)
          report_mismatch("out_id", 64'(result.out_id), 64'(want.out_id));
        if (result.out_age !== want.out_age)
          report_mismatch("out_age", 64'(result.out_age), 64'(want.out_age));
        if (result.out_urgent !== want.out_urgent)
          report_mismatch("out_urgent", 64'(result.out_urgent), 64'(want.out_urgent));
        if (result.last !== want.last)
          report_mismatch("last", 64'(result.last), 64'(want.last));
      end
    end
  end

  // Commands that find nothing stored: list, delete and the ignored kind.
  task automatic test_empty_list();
    send_cmd(KIND_LIST, $urandom(), 7'($urandom_range(0, 127)), 1'b0);
    send_cmd(KIND_DELETE, 32'hFFFF_FFFF, 7'd127, 1'b1);
    send_cmd(KIND_UNUSED, 32'h0, 7'd0, 1'b0);
    send_cmd(KIND_LIST, 32'h0, 7'd0, 1'b1);
  endtask

  // Urgent entries must land behind earlier urgent ones and ahead of every
  // normal entry, with the field extremes carried through unchanged.
  task automatic test_class_ordering();
    send_cmd(KIND_INSERT, 32'h0000_0000, 7'd0, 1'b0);
    send_cmd(KIND_INSERT, 32'hFFFF_FFFF, 7'd127, 1'b0);
    send_cmd(KIND_INSERT, 32'h5555_5555, 7'h2A, 1'b1);
    send_cmd(KIND_INSERT, 32'hAAAA_AAAA, 7'h55, 1'b1);
    send_cmd(KIND_INSERT, 32'h0000_1234, 7'd9, 1'b0);
    send_cmd(KIND_LIST, 32'h0, 7'd0, 1'b0);
  endtask

  // Delete misses, a duplicate ID where only the first copy goes, and the
  // removal of the head and the tail. The ignored kind carries full data here.
  task automatic test_delete_cases();
    send_cmd(KIND_DELETE, 32'h8000_0000, 7'd0, 1'b0);
    send_cmd(KIND_INSERT, 32'h0000_1234, 7'd77, 1'b1);
    send_cmd(KIND_DELETE, 32'h0000_1234, 7'd127, 1'b0);
    send_cmd(KIND_DELETE, 32'h5555_5555, 7'd0, 1'b1);
    send_cmd(KIND_UNUSED, 32'hFFFF_FFFF, 7'd127, 1'b1);
    send_cmd(KIND_DELETE, 32'h0000_1234, 7'd0, 1'b0);
    send_cmd(KIND_LIST, 32'hFFFF_FFFF, 7'd127, 1'b1);
  endtask

  // With only urgent entries stored, a new urgent entry goes at the tail.
  task automatic test_all_urgent();
    entry_t snapshot[$];
    snapshot = roster;
    foreach (snapshot[i]) send_cmd(KIND_DELETE, snapshot[i].id, 7'd0, 1'b0);
    send_cmd(KIND_INSERT, 32'h0000_0011, 7'd1, 1'b1);
    send_cmd(KIND_INSERT, 32'h0000_0022, 7'd2, 1'b1);
    send_cmd(KIND_INSERT, 32'h0000_0033, 7'd3, 1'b1);
    send_cmd(KIND_LIST, 32'h0, 7'd0, 1'b0);
    send_cmd(KIND_INSERT, 32'h0000_0044, 7'd4, 1'b0);
    send_cmd(KIND_INSERT, 32'h0000_0055, 7'd5, 1'b1);
    send_cmd(KIND_LIST, 32'h0, 7'd0, 1'b0);
  endtask

  // Fills the list back to back with random entries, then checks that an
  // insert of either class into a full list is refused, and lists all of it.
  task automatic test_fill_to_capacity();
    steady = 1'b1;
    while (roster.size() < DEPTH)
      send_cmd(KIND_INSERT, $urandom(), 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    send_cmd(KIND_INSERT, $urandom(), 7'($urandom_range(0, 127)), 1'b1);
    send_cmd(KIND_INSERT, $urandom(), 7'($urandom_range(0, 127)), 1'b0);
    send_cmd(KIND_LIST, $urandom(), 7'($urandom_range(0, 127)), 1'b0);
    // The sender stops here until the full list has come back.
    wait_for_results();
    steady = 1'b0;
  endtask

  // Random traffic with bursts and gaps. IDs are often drawn from a small set
  // so that duplicates occur, and most deletes name an entry that is stored.
  task automatic test_random_traffic(input int count);
    int pick;
    int insert_share;
    logic [31:0] id;
    for (int n = 0; n < count; n++) begin
      pick         = $urandom_range(0, 99);
      insert_share = (roster.size() < DEPTH / 2) ? 60 : 35;
      if ($urandom_range(0, 3) == 0) id = $urandom();
      else id = {28'h0, 4'($urandom_range(0, 15))};
      if (pick < 5) begin
        send_cmd(KIND_UNUSED, id, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end else if (pick < 17) begin
        send_cmd(KIND_LIST, id, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end else if (pick < 17 + insert_share) begin
        send_cmd(KIND_INSERT, id, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end else begin
        if (roster.size() != 0 && $urandom_range(0, 9) < 7)
          id = roster[$urandom_range(0, roster.size() - 1)].id;
        send_cmd(KIND_DELETE, id, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end
      if (n == count / 2) wait_for_results();
    end
  endtask

  initial begin
    start      <= 1'b0;
    cmd        <= '0;
    rst        <= 1'b1;
    steady     = 1'b0;
    burst_left = $urandom_range(1, 8);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_class_ordering();
    test_delete_cases();
    test_all_urgent();
    test_fill_to_capacity();
    test_random_traffic(50);

    // Let every outstanding result arrive, then watch a while longer so that a
    // stray result after the last expected one is still caught.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_res.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Far beyond the slowest correct run: each command walks at most the whole list, plus a short gap.
  initial begin
    #2_000_000;
    $display("%0t: run did not finish in time", $realtime);
    $display("== FAIL ==");
    $finish;
  end

endmodule
